// ===== design/cpd_pkg.sv =====
// Shared types and constants for the control packet deframer.
// No dependencies; the other design files except cpd_ram refer to this package by scoped names.
`default_nettype none
package cpd_pkg;

  // Packet store depth, range 4 to 64
  localparam int unsigned BUFFER_DEPTH = 64;
  localparam int unsigned IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int unsigned LEN_W        = 7;
  // two banks of the store: one filling, one draining
  localparam int unsigned RAM_AW       = IDX_W + 1;
  localparam int unsigned RAM_DEPTH    = 2 ** RAM_AW;

  localparam logic [7:0]  START_MARK_A  = 8'hAA;
  localparam logic [7:0]  START_MARK_B  = 8'h55;
  localparam logic [7:0]  END_MARK_HI   = 8'hEB;
  localparam logic [7:0]  END_MARK_LO   = 8'hAA;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  // Register index decoded from the APB address
  localparam logic REG_GAP_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } back_state_e;

  // One completed packet waiting for the back end
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage
`default_nettype wire

// ===== design/cpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none
module cpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/cpd_queue.sv =====
// Two-entry descriptor queue between the front (framer) and back (emitter).
// Depends on cpd_pkg.
`default_nettype none
module cpd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire cpd_pkg::desc_t      desc_i,
  input  wire logic                pop_i,
  output cpd_pkg::desc_t           head_o,
  output cpd_pkg::q_status_t       status_o
);

  cpd_pkg::desc_t ent_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= desc_i;
    end
  end

  assign head_o         = ent_q[rd_ptr_q];
  assign status_o.full  = count_q == 2'd2;
  assign status_o.empty = count_q == 2'd0;

endmodule
`default_nettype wire

// ===== design/cpd_front.sv =====
// Front end: timeout check, start-marker filter, store write, end-marker detect.
// Depends on cpd_pkg; writes the packet RAM and pushes descriptors to cpd_queue.
`default_nettype none
module cpd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [15:0]         gap_timeout_i,
  input  wire logic                rx_valid_i,
  output logic                     rx_ready_o,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic [31:0]         time_ms_i,
  input  wire cpd_pkg::q_status_t  q_status_i,
  output logic                     push_o,
  output cpd_pkg::desc_t           desc_o,
  output cpd_pkg::ram_wr_t         ram_wr_o,
  output logic                     bank_o
);

  logic [cpd_pkg::LEN_W-1:0] fill_q, fill_d;
  logic [31:0]               prev_time_q;
  logic                      bank_q, bank_d;
  logic [7:0]                last_q;
  logic                      accept;
  logic                      timed_out;
  logic [cpd_pkg::LEN_W-1:0] fill_eff;
  logic [cpd_pkg::LEN_W-1:0] fill_inc;
  logic [31:0]               gap;
  logic                      is_start;

  // a new bank must be free before a byte can be taken
  assign rx_ready_o = !q_status_i.full;
  assign accept     = rx_valid_i && rx_ready_o;

  always_comb begin
    gap       = time_ms_i - prev_time_q;
    timed_out = (gap > 32'(gap_timeout_i)) && (fill_q != '0);
    fill_eff  = timed_out ? '0 : fill_q;
    fill_inc  = fill_eff + cpd_pkg::LEN_W'(1);
    is_start  = (rx_byte_i == cpd_pkg::START_MARK_A) || (rx_byte_i == cpd_pkg::START_MARK_B);

    fill_d        = fill_q;
    bank_d        = bank_q;
    push_o        = 1'b0;
    desc_o.bank   = bank_q;
    desc_o.len    = fill_inc;
    ram_wr_o.en   = 1'b0;
    ram_wr_o.addr = {bank_q, fill_eff[cpd_pkg::IDX_W-1:0]};
    ram_wr_o.data = rx_byte_i;

    if (accept) begin
      priority if (fill_eff == '0 && !is_start) begin
        fill_d = '0;
      end else if (fill_eff == cpd_pkg::LEN_W'(cpd_pkg::BUFFER_DEPTH)) begin
        fill_d = '0;   // overflow: drop byte and packet
      end else begin
        ram_wr_o.en = 1'b1;
        if (fill_eff != '0 && last_q == cpd_pkg::END_MARK_HI &&
            rx_byte_i == cpd_pkg::END_MARK_LO) begin
          push_o = 1'b1;
          fill_d = '0;
          bank_d = !bank_q;
        end else begin
          fill_d = fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      prev_time_q <= '0;
      bank_q      <= 1'b0;
    end else if (accept) begin
      fill_q      <= fill_d;
      prev_time_q <= time_ms_i;
      bank_q      <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_wr_o.en) begin
      last_q <= rx_byte_i;
    end
  end

  assign bank_o = bank_q;

endmodule
`default_nettype wire

// ===== design/cpd_back.sv =====
// Back end: reads a completed packet from its RAM bank and emits it beat by beat.
// Depends on cpd_pkg; pops cpd_queue after the last beat.
`default_nettype none
module cpd_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cpd_pkg::desc_t             head_i,
  input  wire cpd_pkg::q_status_t         q_status_i,
  output logic                            pop_o,
  output logic                            re_o,
  output logic [cpd_pkg::RAM_AW-1:0]      raddr_o,
  input  wire logic [7:0]                 rdata_i,
  output logic                            pkt_valid_o,
  input  wire logic                       pkt_ready_i,
  output logic [7:0]                      pkt_byte_o,
  output logic                            pkt_last_o,
  output logic [cpd_pkg::LEN_W-1:0]       pkt_length_o
);

  cpd_pkg::back_state_e      state_q, state_d;
  logic [cpd_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                      is_last;

  assign is_last = (cpd_pkg::LEN_W'(idx_q) + cpd_pkg::LEN_W'(1)) == head_i.len;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    re_o        = 1'b0;
    pkt_valid_o = 1'b0;
    unique case (state_q)
      cpd_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          idx_d   = '0;
          state_d = cpd_pkg::BK_READ;
        end
      end
      cpd_pkg::BK_READ: begin
        re_o    = 1'b1;
        state_d = cpd_pkg::BK_SHOW;
      end
      cpd_pkg::BK_SHOW: begin
        pkt_valid_o = 1'b1;
        if (pkt_ready_i) begin
          if (is_last) begin
            pop_o   = 1'b1;
            state_d = cpd_pkg::BK_IDLE;
          end else begin
            idx_d   = idx_q + cpd_pkg::IDX_W'(1);
            state_d = cpd_pkg::BK_READ;
          end
        end
      end
      default: state_d = cpd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpd_pkg::BK_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign raddr_o      = {head_i.bank, idx_q};
  assign pkt_byte_o   = rdata_i;
  assign pkt_last_o   = is_last;
  assign pkt_length_o = head_i.len;

endmodule
`default_nettype wire

// ===== design/control_packet_deframer.sv =====
// Control packet deframer: bytes in, packets delimited by AA/55 ... EB AA out.
// First beat: descriptor registered in the queue, then back end BK_IDLE, BK_READ, BK_SHOW.
// Throughput: one input byte per cycle while a store bank is free (input stalls only
// while one packet drains and another completes); each output beat is a RAM read, then
// an output hold until taken, set by the back end's read-then-show sequence.
// Reset: async active low; store empty, timestamp 0, timeout 50 ms; no clearing pass.
`default_nettype none
module control_packet_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input beats
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [31:0] time_ms_i,
  // output beats
  output logic             pkt_valid_o,
  input  wire logic        pkt_ready_i,
  output logic [7:0]       pkt_byte_o,
  output logic             pkt_last_o,
  output logic [6:0]       pkt_length_o
);

  // ---------------------------------------------------------------------------
  // Configuration register: one 16-bit gap timeout at byte address 0.
  // ---------------------------------------------------------------------------
  logic [15:0] gap_timeout_q;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_timeout_q <= cpd_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == cpd_pkg::REG_GAP_TIMEOUT) begin
      gap_timeout_q <= pwdata[15:0];
    end
  end

  assign prdata = (reg_idx == cpd_pkg::REG_GAP_TIMEOUT) ? {16'd0, gap_timeout_q} : 32'd0;

  // ---------------------------------------------------------------------------
  // Front end fills one bank of the store; a completed packet's bank and length
  // go into the descriptor queue, and the front switches to the other bank.
  // The front stalls only while both banks hold packets not yet drained.
  // ---------------------------------------------------------------------------
  cpd_pkg::q_status_t q_status;
  cpd_pkg::desc_t     push_desc;
  cpd_pkg::desc_t     head;
  cpd_pkg::ram_wr_t   ram_wr;
  logic               push;
  logic               pop;
  logic               front_bank;
  logic               ram_re;
  logic [cpd_pkg::RAM_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  cpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gap_timeout_i (gap_timeout_q),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .rx_byte_i     (rx_byte_i),
    .time_ms_i     (time_ms_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .desc_o        (push_desc),
    .ram_wr_o      (ram_wr),
    .bank_o        (front_bank)
  );

  cpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (push_desc),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Two banks of BUFFER_DEPTH bytes; the write and read sides always hit
  // different banks.
  cpd_ram #(
    .WIDTH (8),
    .DEPTH (cpd_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back end walks the head packet and holds each beat until taken.
  cpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .re_o         (ram_re),
    .raddr_o      (ram_raddr),
    .rdata_i      (ram_rdata),
    .pkt_valid_o  (pkt_valid_o),
    .pkt_ready_i  (pkt_ready_i),
    .pkt_byte_o   (pkt_byte_o),
    .pkt_last_o   (pkt_last_o),
    .pkt_length_o (pkt_length_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a beat is only shown for a queued packet
  a_valid_has_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_o |-> !q_status.empty)
    else $error("output beat without queued packet");

  // the bank being filled is never the bank being drained
  a_bank_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_ready_o && !q_status.empty) |-> (head.bank != front_bank))
    else $error("front writes into the draining bank");

  // the last beat closes the packet; no beat follows in the next cycle
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_valid_o && pkt_ready_i && pkt_last_o) |=> !pkt_valid_o)
    else $error("beat shown right after last beat");

  // shortest packet is start marker plus EB AA
  a_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_o |-> (pkt_length_o >= 7'd3))
    else $error("packet shorter than three bytes");

endmodule
`default_nettype wire
